### hw/rtl/wsp_pkg.sv
// Shared constants, types and helpers for the 802.11 SSID parser.
package wsp_pkg;

	localparam int SSID_MAX   = 32;
	localparam int SSID_AW    = $clog2(SSID_MAX);
	localparam int RAM_DEPTH  = 2 * SSID_MAX;
	localparam int RAM_AW     = SSID_AW + 1;
	localparam int LEN_W      = 6;
	localparam int ADDR_W     = 48;

	localparam logic [5:0] POS_MAX     = 6'd63;
	localparam logic [5:0] HDR_LEN     = 6'd24;
	localparam logic [5:0] ADDR_OFF    = 6'd10;
	localparam logic [5:0] ADDR_END    = 6'd15;
	localparam logic [5:0] BODY_START  = 6'd36;   // header plus 12-byte fixed body

	localparam logic [7:0] TYPE_MASK    = 8'h0C;
	localparam logic [7:0] TYPE_MGMT    = 8'h00;
	localparam logic [7:0] SUBTYPE_MASK = 8'hF0;
	localparam logic [7:0] ST_PROBE_REQ = 8'h40;
	localparam logic [7:0] ST_PROBE_RSP = 8'h50;
	localparam logic [7:0] ST_BEACON    = 8'h80;
	localparam logic [7:0] EID_SSID     = 8'h00;

	localparam logic [1:0] PH_TAG  = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;
	localparam logic [1:0] PH_STOP = 2'd3;

	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_CHAR    = 1'b1;

	// frame result handed from parser to emitter
	typedef struct packed {
		logic              acc;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic              bank;
	} job_t;

	function automatic logic kind_ok(input logic [7:0] fc);
		logic [7:0] st;
		st = fc & SUBTYPE_MASK;
		kind_ok = ((fc & TYPE_MASK) == TYPE_MGMT) &&
			(st == ST_BEACON || st == ST_PROBE_RSP || st == ST_PROBE_REQ);
	endfunction

endpackage

### hw/rtl/wsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/wsp_parser.sv
// Byte parser: header capture, element walk, SSID writes and frame result handoff.
module wsp_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   in_byte,
	input  logic                         in_last,
	output logic                         wr_en,
	output logic [wsp_pkg::RAM_AW-1:0]   wr_addr,
	output logic [7:0]                   wr_data,
	output logic                         job_valid,
	output wsp_pkg::job_t                job,
	input  logic                         job_take
);

	logic [5:0]                      pos_q;
	logic [7:0]                      fc_q;
	logic [wsp_pkg::ADDR_W-1:0]      addr_q;
	logic [1:0]                      phase_q;
	logic [7:0]                      rem_q;
	logic                            is_ssid_q;
	logic [wsp_pkg::LEN_W-1:0]       cnt_q;
	logic                            done_q;
	logic                            bank_q;
	logic                            pend_q;
	wsp_pkg::job_t                   job_q;

	logic                            acc_in;
	logic [7:0]                      fc_e;
	logic [wsp_pkg::ADDR_W-1:0]      addr_e;
	logic                            kok;
	logic [5:0]                      start;
	logic                            elem;
	logic [1:0]                      phase_n;
	logic [7:0]                      rem_n;
	logic                            is_ssid_n;
	logic                            done_n;
	logic [wsp_pkg::LEN_W-1:0]       cnt_n;
	logic                            acc;

	assign in_ready = !pend_q || job_take;
	assign acc_in   = in_valid && in_ready;

	assign fc_e   = (pos_q == 6'd0) ? in_byte : fc_q;
	assign addr_e = (pos_q >= wsp_pkg::ADDR_OFF && pos_q <= wsp_pkg::ADDR_END) ?
		{addr_q[wsp_pkg::ADDR_W-9:0], in_byte} : addr_q;
	assign kok    = wsp_pkg::kind_ok(fc_e);
	assign start  = ((fc_e & wsp_pkg::SUBTYPE_MASK) == wsp_pkg::ST_PROBE_REQ) ?
		wsp_pkg::HDR_LEN : wsp_pkg::BODY_START;
	assign elem   = kok && (pos_q >= start);

	always_comb begin
		phase_n   = phase_q;
		rem_n     = rem_q;
		is_ssid_n = is_ssid_q;
		done_n    = done_q;
		wr_en     = 1'b0;
		if (elem) begin
			unique case (phase_q)
				wsp_pkg::PH_TAG: begin
					is_ssid_n = (in_byte == wsp_pkg::EID_SSID);
					phase_n   = wsp_pkg::PH_LEN;
				end
				wsp_pkg::PH_LEN: begin
					rem_n = in_byte;
					if (in_byte == 8'd0) begin
						if (is_ssid_q) begin
							done_n  = 1'b1;
							phase_n = wsp_pkg::PH_STOP;
						end else begin
							phase_n = wsp_pkg::PH_TAG;
						end
					end else begin
						phase_n = wsp_pkg::PH_BODY;
					end
				end
				wsp_pkg::PH_BODY: begin
					wr_en = acc_in && is_ssid_q &&
						(cnt_q < wsp_pkg::LEN_W'(wsp_pkg::SSID_MAX));
					rem_n = rem_q - 8'd1;
					if (rem_q == 8'd1) begin
						if (is_ssid_q) begin
							done_n  = 1'b1;
							phase_n = wsp_pkg::PH_STOP;
						end else begin
							phase_n = wsp_pkg::PH_TAG;
						end
					end
				end
				wsp_pkg::PH_STOP: begin
				end
			endcase
		end
	end

	assign cnt_n   = cnt_q + wsp_pkg::LEN_W'(wr_en);
	assign wr_addr = {bank_q, cnt_q[wsp_pkg::SSID_AW-1:0]};
	assign wr_data = in_byte;
	assign acc     = kok && (pos_q >= wsp_pkg::HDR_LEN - 6'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			fc_q      <= '0;
			addr_q    <= '0;
			phase_q   <= wsp_pkg::PH_TAG;
			rem_q     <= '0;
			is_ssid_q <= 1'b0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			bank_q    <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			if (acc_in && in_last) begin
				pos_q     <= '0;
				fc_q      <= '0;
				addr_q    <= '0;
				phase_q   <= wsp_pkg::PH_TAG;
				rem_q     <= '0;
				is_ssid_q <= 1'b0;
				cnt_q     <= '0;
				done_q    <= 1'b0;
				bank_q    <= !bank_q;
				pend_q    <= 1'b1;
			end else begin
				if (acc_in) begin
					if (pos_q < wsp_pkg::POS_MAX) begin
						pos_q <= pos_q + 6'd1;
					end
					fc_q      <= fc_e;
					addr_q    <= addr_e;
					phase_q   <= phase_n;
					rem_q     <= rem_n;
					is_ssid_q <= is_ssid_n;
					cnt_q     <= cnt_n;
					done_q    <= done_n;
				end
				if (job_take) begin
					pend_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && in_last) begin
			job_q.acc  <= acc;
			job_q.addr <= acc ? addr_e : '0;
			job_q.len  <= (acc && done_n) ? cnt_n : '0;
			job_q.bank <= bank_q;
		end
	end

	assign job_valid = pend_q;
	assign job       = job_q;

endmodule

### hw/rtl/wsp_emitter.sv
// Result emitter: summary word then SSID bytes read from RAM, with output register.
module wsp_emitter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	input  wsp_pkg::job_t                job,
	output logic                         job_take,
	output logic                         rd_en,
	output logic [wsp_pkg::RAM_AW-1:0]   rd_addr,
	input  logic [7:0]                   rd_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_kind,
	output logic                         out_acc,
	output logic [wsp_pkg::ADDR_W-1:0]   out_addr,
	output logic [wsp_pkg::LEN_W-1:0]    out_len,
	output logic [7:0]                   out_char,
	output logic                         out_last
);

	logic                            busy_q;
	logic [wsp_pkg::LEN_W-1:0]       idx_q;
	wsp_pkg::job_t                   cur_q;

	logic                            valid_s1;
	logic                            kind_s1;
	logic                            last_s1;
	logic                            acc_s1;
	logic [wsp_pkg::ADDR_W-1:0]      addr_s1;
	logic [wsp_pkg::LEN_W-1:0]       len_s1;

	logic                            valid_q;
	logic                            kind_q;
	logic                            last_q;
	logic                            acc_q;
	logic [wsp_pkg::ADDR_W-1:0]      addr_q;
	logic [wsp_pkg::LEN_W-1:0]       len_q;
	logic [7:0]                      char_q;

	logic                            advance;
	logic                            gen_last;
	logic [wsp_pkg::LEN_W-1:0]       idx_m1;

	assign advance  = !valid_q || out_ready;
	assign gen_last = busy_q && (idx_q == cur_q.len);
	assign job_take = job_valid && (!busy_q || (advance && gen_last));
	assign idx_m1   = idx_q - wsp_pkg::LEN_W'(1);
	assign rd_en    = advance;
	assign rd_addr  = {cur_q.bank, idx_m1[wsp_pkg::SSID_AW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (job_take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance && busy_q) begin
				idx_q <= idx_q + wsp_pkg::LEN_W'(1);
				if (gen_last) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				valid_s1 <= busy_q;
				valid_q  <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			cur_q <= job;
		end
		if (advance) begin
			kind_s1 <= (idx_q != '0) ? wsp_pkg::KIND_CHAR : wsp_pkg::KIND_SUMMARY;
			last_s1 <= gen_last;
			acc_s1  <= cur_q.acc;
			addr_s1 <= cur_q.addr;
			len_s1  <= cur_q.len;
			kind_q  <= kind_s1;
			last_q  <= last_s1;
			acc_q   <= acc_s1;
			addr_q  <= addr_s1;
			len_q   <= len_s1;
			char_q  <= (kind_s1 == wsp_pkg::KIND_CHAR) ? rd_data : 8'd0;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_acc   = acc_q;
	assign out_addr  = addr_q;
	assign out_len   = len_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule

### hw/rtl/wifi_mgmt_frame_ssid_parser.sv
// Top level of the 802.11 management frame SSID parser.
//
// Input stream: one frame byte per word on s_tdata, s_tlast on the final byte.
// Bytes are taken one per cycle while s_tready is high. After the last byte
// of a frame the block emits a summary word (m_tuser 0) with accept flag,
// transmitter address and SSID length, then one word per SSID byte
// (m_tuser 1); m_tlast marks the final word of the frame's results.
// A result passes from the holding slot through the emitter's stage-1 and
// output registers; results then leave one per cycle while m_tready is high.
// SSID bytes sit in a two-bank RAM: one bank fills while the other is read
// out. A frame's results are queued in one holding slot; s_tready drops only
// when that slot is full and the emitter is still draining the frame before,
// i.e. when a frame is shorter than the result run of the previous one.
// When m_tready is low the output word holds and the pipeline stops; input
// keeps flowing until the holding slot is needed.
// Reset clears all parser and emitter control state; the RAM needs no clear,
// since only entries written for the current frame are read.
module wifi_mgmt_frame_ssid_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] frame_byte
	input  logic        s_tlast,   // end_of_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [0] accepted, [48:1] transmitter_address,
	                               // [54:49] ssid_length, [62:55] ssid_char, [63] zero
	output logic        m_tuser,   // item_kind
	output logic        m_tlast    // run_last
);

	logic                          wr_en;
	logic [wsp_pkg::RAM_AW-1:0]    wr_addr;
	logic [7:0]                    wr_data;
	logic                          rd_en;
	logic [wsp_pkg::RAM_AW-1:0]    rd_addr;
	logic [7:0]                    rd_data;
	logic                          job_valid;
	logic                          job_take;
	wsp_pkg::job_t                 job;
	logic                          out_acc;
	logic [wsp_pkg::ADDR_W-1:0]    out_addr;
	logic [wsp_pkg::LEN_W-1:0]     out_len;
	logic [7:0]                    out_char;

	wsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	wsp_ram #(
		.WIDTH (8),
		.DEPTH (wsp_pkg::RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	wsp_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_acc   (out_acc),
		.out_addr  (out_addr),
		.out_len   (out_len),
		.out_char  (out_char),
		.out_last  (m_tlast)
	);

	assign m_tdata = {1'b0, out_char, out_len, out_addr, out_acc};

	// input stalls only while a finished frame waits for the emitter
	a_stall_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> job_valid)
		else $error("input stalled without a pending frame result");

	// a summary that is not the last word must announce SSID bytes
	a_summary_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == wsp_pkg::KIND_SUMMARY && !m_tlast) |->
		(out_acc && out_len != '0))
		else $error("summary not last but no SSID bytes follow");

	// SSID byte words only come from accepted frames
	a_char_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == wsp_pkg::KIND_CHAR) |-> (out_acc && out_len != '0))
		else $error("SSID byte for a rejected or empty frame");

	// a pending job is never dropped: the slot stays full until the emitter takes it
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && !job_take) |=> job_valid)
		else $error("pending frame result lost");

endmodule

### test/tb.sv
// Self-checking testbench for the 802.11 management frame SSID parser.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int IDLE_PCT    = 32;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [7:0] b;
		logic       eof;
	} frame_word_t;

	typedef struct packed {
		logic                       kind;
		logic                       acc;
		logic [wsp_pkg::ADDR_W-1:0] ta;
		logic [wsp_pkg::LEN_W-1:0]  len;
		logic [7:0]                 ch;
		logic                       last;
	} ssid_rec_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] frame_byte
	logic        s_tlast  = 1'b0;    // end_of_frame
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;            // [0] accepted, [48:1] transmitter_address,
	                                 // [54:49] ssid_length, [62:55] ssid_char, [63] zero
	logic        m_tuser;            // item_kind
	logic        m_tlast;            // run_last

	wifi_mgmt_frame_ssid_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	frame_word_t frame_words_q[$];
	ssid_rec_t   ssid_expect_q[$];
	logic [7:0]  frame_buf[$];
	ssid_rec_t   head_rec;

	int cyc;
	int fail_cnt;
	int frames_queued;
	int bytes_sent;
	int frames_acc;
	int frames_with_ssid;
	int words_checked;
	int chars_checked;
	int hold_left;
	logic hold_req;
	logic hold_done;

	// parser shadow state
	logic [5:0]                 fpos;
	logic [7:0]                 fctl;
	logic [wsp_pkg::ADDR_W-1:0] tx_addr;
	logic [1:0]                 ie_phase;
	logic [7:0]                 ie_left;
	logic                       ie_ssid;
	logic [7:0]                 ssid_buf[wsp_pkg::SSID_MAX];
	logic [wsp_pkg::LEN_W-1:0]  ssid_fill;
	logic                       ssid_seen;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic mgmt_kind_ok(input logic [7:0] fc);
		logic [7:0] sub;
		sub = fc & wsp_pkg::SUBTYPE_MASK;
		return ((fc & wsp_pkg::TYPE_MASK) == wsp_pkg::TYPE_MGMT) &&
			(sub == wsp_pkg::ST_BEACON || sub == wsp_pkg::ST_PROBE_RSP ||
			sub == wsp_pkg::ST_PROBE_REQ);
	endfunction

	function automatic void clear_shadow();
		fpos = '0;
		fctl = '0;
		tx_addr = '0;
		ie_phase = wsp_pkg::PH_TAG;
		ie_left = '0;
		ie_ssid = 1'b0;
		ssid_fill = '0;
		ssid_seen = 1'b0;
	endfunction

	function automatic void end_element();
		if (ie_ssid) begin
			ssid_seen = 1'b1;
			ie_phase = wsp_pkg::PH_STOP;
		end else begin
			ie_phase = wsp_pkg::PH_TAG;
		end
	endfunction

	function automatic void walk_element(input logic [7:0] b);
		unique case (ie_phase)
			wsp_pkg::PH_TAG: begin
				ie_ssid = (b == wsp_pkg::EID_SSID);
				ie_phase = wsp_pkg::PH_LEN;
			end
			wsp_pkg::PH_LEN: begin
				ie_left = b;
				if (b == 8'd0)
					end_element();
				else
					ie_phase = wsp_pkg::PH_BODY;
			end
			wsp_pkg::PH_BODY: begin
				if (ie_ssid && ssid_fill < wsp_pkg::SSID_MAX) begin
					ssid_buf[ssid_fill[wsp_pkg::SSID_AW-1:0]] = b;
					ssid_fill = ssid_fill + 1'b1;
				end
				ie_left = ie_left - 8'd1;
				if (ie_left == 8'd0)
					end_element();
			end
			default: ;
		endcase
	endfunction

	// Runs one accepted byte through the shadow parser; on the frame end it
	// queues the summary word and the SSID words that should follow.
	function automatic void parse_frame_byte(input logic [7:0] b, input logic eof);
		logic [5:0]                p;
		logic [5:0]                first_ie;
		logic                      hit;
		logic [wsp_pkg::LEN_W-1:0] n;
		int                        k;
		p = fpos;
		if (p == 6'd0)
			fctl = b;
		if (p >= wsp_pkg::ADDR_OFF && p <= wsp_pkg::ADDR_END)
			tx_addr = {tx_addr[wsp_pkg::ADDR_W-9:0], b};
		if (mgmt_kind_ok(fctl)) begin
			first_ie = ((fctl & wsp_pkg::SUBTYPE_MASK) == wsp_pkg::ST_PROBE_REQ) ?
				wsp_pkg::HDR_LEN : wsp_pkg::BODY_START;
			if (p >= first_ie)
				walk_element(b);
		end
		if (fpos != wsp_pkg::POS_MAX)
			fpos = fpos + 6'd1;
		if (eof) begin
			hit = mgmt_kind_ok(fctl) && (int'(p) + 1 >= int'(wsp_pkg::HDR_LEN));
			n = (hit && ssid_seen) ? ssid_fill : '0;
			if (hit)
				frames_acc++;
			if (n != 0)
				frames_with_ssid++;
			ssid_expect_q.push_back('{wsp_pkg::KIND_SUMMARY, hit, hit ? tx_addr : '0, n,
				8'h00, n == 0});
			for (k = 0; k < int'(n); k++)
				ssid_expect_q.push_back('{wsp_pkg::KIND_CHAR, 1'b1, tx_addr, n, ssid_buf[k],
					k + 1 == int'(n)});
			clear_shadow();
		end
	endfunction

	function automatic int idle_pct();
		return ((cyc % 1000) < 200) ? 0 : IDLE_PCT;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
			clear_shadow();
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				parse_frame_byte(s_tdata, s_tlast);
				bytes_sent++;
			end
			if (frame_words_q.size() > 0 && $urandom_range(99) >= idle_pct()) begin
				s_tvalid <= 1'b1;
				s_tdata <= frame_words_q[0].b;
				s_tlast <= frame_words_q[0].eof;
				void'(frame_words_q.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string what, input logic [47:0] want,
		input logic [47:0] got);
		if (got !== want) begin
			$display("%0t mismatch %s: expected %h, actual %h", $time, what, want, got);
			fail_cnt++;
		end
	endtask

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (ssid_expect_q.size() == 0) begin
					$display("%0t unexpected word: expected none, actual tuser %b tdata %h tlast %b",
						$time, m_tuser, m_tdata, m_tlast);
					fail_cnt++;
				end else begin
					head_rec = ssid_expect_q.pop_front();
					check_field("item_kind", head_rec.kind, m_tuser);
					check_field("accepted", head_rec.acc, m_tdata[0]);
					check_field("transmitter_address", head_rec.ta, m_tdata[48:1]);
					check_field("ssid_length", head_rec.len, m_tdata[54:49]);
					check_field("ssid_char", head_rec.ch, m_tdata[62:55]);
					check_field("tdata pad", 48'd0, m_tdata[63]);
					check_field("run_last", head_rec.last, m_tlast);
					words_checked++;
					if (head_rec.kind == wsp_pkg::KIND_CHAR)
						chars_checked++;
				end
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct());
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("%0t timeout with %0d words still expected", $time,
				ssid_expect_q.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic rand_fill(input int n);
		repeat (n) frame_buf.push_back(8'($urandom_range(255)));
	endtask

	task automatic begin_mgmt(input logic [7:0] fc, input logic [47:0] ta);
		int i;
		frame_buf = {};
		frame_buf.push_back(fc);
		rand_fill(9);
		for (i = 5; i >= 0; i--)
			frame_buf.push_back(ta[8*i +: 8]);
		rand_fill(8);
		if ((fc & wsp_pkg::SUBTYPE_MASK) != wsp_pkg::ST_PROBE_REQ)
			rand_fill(12);
	endtask

	task automatic add_element(input logic [7:0] tag, input logic [7:0] len);
		frame_buf.push_back(tag);
		frame_buf.push_back(len);
		rand_fill(len);
	endtask

	// cut > 0 trims the frame to that many bytes
	task automatic ship_frame(input int cut);
		int i;
		if (cut > 0)
			while (frame_buf.size() > cut)
				void'(frame_buf.pop_back());
		for (i = 0; i < frame_buf.size(); i++)
			frame_words_q.push_back('{frame_buf[i], i == frame_buf.size() - 1});
		frames_queued++;
	endtask

	function automatic logic [47:0] rand_addr();
		return {16'($urandom), $urandom};
	endfunction

	task automatic wait_drained();
		while (frame_words_q.size() > 0 || s_tvalid || ssid_expect_q.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		begin_mgmt(wsp_pkg::ST_PROBE_REQ, 48'hFFFF_FFFF_FFFF);
		add_element(wsp_pkg::EID_SSID, 8'd32);
		ship_frame(0);
		// one-byte frame right behind a full result run
		frame_buf = {wsp_pkg::ST_BEACON};
		ship_frame(0);
		// second SSID element must be ignored
		begin_mgmt(wsp_pkg::ST_PROBE_RSP, 48'h0);
		add_element(wsp_pkg::EID_SSID, 8'd2);
		add_element(wsp_pkg::EID_SSID, 8'd1);
		ship_frame(0);
		// empty SSID after an empty foreign element
		begin_mgmt(wsp_pkg::ST_BEACON | 8'h03, rand_addr());
		add_element(8'h01, 8'd0);
		add_element(wsp_pkg::EID_SSID, 8'd0);
		ship_frame(0);

		wait_drained();

		@(negedge clk);
		hold_req = 1'b1;
		// oversize SSID, frame runs past the position limit
		begin_mgmt(wsp_pkg::ST_PROBE_REQ, rand_addr());
		add_element(wsp_pkg::EID_SSID, 8'd40);
		ship_frame(0);
		// SSID cut by the frame end
		begin_mgmt(wsp_pkg::ST_PROBE_REQ, rand_addr());
		add_element(wsp_pkg::EID_SSID, 8'd10);
		ship_frame(30);
		// lone tag byte at the end
		begin_mgmt(wsp_pkg::ST_PROBE_REQ, rand_addr());
		frame_buf.push_back(wsp_pkg::EID_SSID);
		ship_frame(0);
		// wrong frame type
		begin_mgmt(8'h44, rand_addr());
		add_element(wsp_pkg::EID_SSID, 8'd3);
		ship_frame(0);
		// one byte short of a header
		begin_mgmt(wsp_pkg::ST_PROBE_REQ, rand_addr());
		ship_frame(23);

		wait_drained();
		repeat (12) @(posedge clk);

		$display("sent %0d frames in %0d bytes: %0d accepted, %0d carrying an SSID",
			frames_queued, bytes_sent, frames_acc, frames_with_ssid);
		$display("checked %0d result words (%0d SSID bytes), one output hold of %0d cycles",
			words_checked, chars_checked, HOLD_CYCLES);
		if (fail_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/wsp_pkg.sv
hw/rtl/wsp_ram.sv
hw/rtl/wsp_parser.sv
hw/rtl/wsp_emitter.sv
hw/rtl/wifi_mgmt_frame_ssid_parser.sv
test/tb.sv
